// ----- src/stig_pkg.sv -----
package stig_pkg;

    // Field and register widths.
    localparam int DRAW_W     = 12;
    localparam int POS_W      = 12;
    localparam int IDX_W      = 12;
    localparam int PBITS_W    = 4;
    localparam int FLEN_W     = 13;
    localparam int CFG_DATA_W = 13;
    localparam int CFG_IDX_W  = 1;

    // Internal widths: residue folding and candidates work on frame-length-sized values.
    localparam int VAL_W   = FLEN_W;
    localparam int PER_W   = 16;
    localparam int EPOCH_W = 4;

    // Largest encoder memory that the block supports.
    localparam int MAX_PERIOD_BITS = 8;

    // Register reset values.
    localparam logic [PBITS_W-1:0] PBITS_RESET = 4'd1;
    localparam logic [FLEN_W-1:0]  FLEN_RESET  = 13'd1024;

    // Epoch marks in the used map: zero means free, live marks run from first to last.
    localparam logic [EPOCH_W-1:0] EPOCH_FREE  = '0;
    localparam logic [EPOCH_W-1:0] EPOCH_FIRST = 4'd1;
    localparam logic [EPOCH_W-1:0] EPOCH_LAST  = '1;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_PERIOD_BITS  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_LENGTH = 1'b1;

    // Controller states.
    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_CHECK_INIT,
        ST_CHECK,
        ST_IDLE,
        ST_FOLD,
        ST_DECIDE,
        ST_EMIT
    } stig_state_t;

endpackage

// ----- src/self_terminating_interleaver_gen_top.sv -----
// Random interleaver generator with residue-preserving (self-terminating) entries.
// Input channel: in_valid / in_stall carries one random_draw per transfer. Each draw
// yields at most one result on the output channel (out_valid / out_stall): accepted,
// position, mapped_index, frame_last and config_error. A register write drops a draw in flight.
// The block works on one draw at a time. From its input transfer a draw passes
// through fold, where the residue unit reduces it modulo 2^m - 1 by folding (one
// fold per cycle, at most two folds for m of six or more, up to 12 for m = 1), decide
// (skipped for a candidate outside the frame) and emit, which sets out_valid.
// Draws rejected before the lookup (bad configuration, draw out of range) go from
// idle straight to emit. The next draw is taken once the result sits in the output
// register, so the used-map memory and the residue unit set the rate. The used map is
// a one-port-write, one-port-read memory of epoch marks. After reset, and after every
// fifteenth frame restart, a clearing pass writes all MAX_LENGTH entries (4096 by
// default) with in_stall high; a configuration check follows, and also follows
// every register write. Register writes restart the frame. While out_stall is high
// the result holds, and the block takes one more draw and holds its result
// internally until the output register frees up.
module self_terminating_interleaver_gen_top
    import stig_pkg::*;
#(
    parameter int MAX_LENGTH = 4096
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic [DRAW_W-1:0]     random_draw,
    output logic                  out_valid,
    input  logic                  out_stall,
    output logic                  accepted,
    output logic [POS_W-1:0]      position,
    output logic [IDX_W-1:0]      mapped_index,
    output logic                  frame_last,
    output logic                  config_error
);

    localparam int AW = $clog2(MAX_LENGTH);
    localparam logic [AW-1:0] LAST_ADDR = AW'(MAX_LENGTH - 1);

    stig_state_t state_reg, state_next;

    logic [PBITS_W-1:0] period_bits_reg;
    logic [FLEN_W-1:0]  frame_length_reg;
    logic               cfg_ok_reg;
    logic [POS_W-1:0]   pos_reg;
    logic [POS_W-1:0]   pos_mod_reg;
    logic [EPOCH_W-1:0] epoch_reg;
    logic               clear_pend_reg;
    logic [AW-1:0]      clr_cnt_reg;
    logic               out_valid_reg;

    logic [DRAW_W-1:0]  draw_reg;
    logic [POS_W-1:0]   item_pos_reg;
    logic [VAL_W-1:0]   x_reg;
    logic [VAL_W-1:0]   cand_reg;
    logic               res_accept_reg;
    logic [IDX_W-1:0]   res_mapped_reg;
    logic               res_last_reg;
    logic               res_err_reg;
    logic               out_accept_reg;
    logic [POS_W-1:0]   out_pos_reg;
    logic [IDX_W-1:0]   out_mapped_reg;
    logic               out_last_reg;
    logic               out_err_reg;

    logic [EPOCH_W-1:0] mem [MAX_LENGTH];
    logic [EPOCH_W-1:0] rd_data_reg;
    logic               mem_we;
    logic [AW-1:0]      mem_waddr;
    logic [EPOCH_W-1:0] mem_wdata;
    logic [AW-1:0]      mem_raddr;

    logic               period_ok;
    logic               length_ok;
    logic [PER_W-1:0]   period_val;
    logic [VAL_W-1:0]   fold_hi;
    logic [VAL_W-1:0]   fold_lo;
    logic [VAL_W-1:0]   fold_sum;
    logic [VAL_W-1:0]   fold_rem;
    logic               fold_done;
    logic [VAL_W-1:0]   cand_calc;
    logic               cand_ok;
    logic               draw_oor;
    logic               entry_used;
    logic [VAL_W-1:0]   pos_inc;
    logic               frame_end;
    logic [POS_W-1:0]   pos_mod_inc;
    logic               epoch_wrap;
    logic               in_xfer;
    logic               out_free;
    logic               cfg_restart;

    // Configuration checks and the period p = 2^m - 1.
    assign period_ok  = (period_bits_reg != '0) && (32'(period_bits_reg) <= MAX_PERIOD_BITS);
    assign length_ok  = (frame_length_reg != '0) && (32'(frame_length_reg) <= MAX_LENGTH);
    assign period_val = (PER_W'(1) << period_bits_reg) - PER_W'(1);

    // Residue unit: one fold of x modulo 2^m - 1 per cycle.
    assign fold_hi   = x_reg >> period_bits_reg;
    assign fold_lo   = x_reg & period_val[VAL_W-1:0];
    assign fold_sum  = fold_hi + fold_lo;
    assign fold_done = (fold_hi == '0);
    assign fold_rem  = (PER_W'(x_reg) == period_val) ? '0 : x_reg;

    // Candidate index: the draw rounded down to a multiple of p, plus the position residue.
    assign cand_calc = VAL_W'(draw_reg) - fold_rem + VAL_W'(pos_mod_reg);
    assign cand_ok   = (cand_calc < frame_length_reg);
    assign draw_oor  = (VAL_W'(random_draw) >= frame_length_reg)
                    || (VAL_W'(pos_reg) >= frame_length_reg);

    // Entry state and position bookkeeping.
    assign entry_used  = (rd_data_reg == epoch_reg);
    assign pos_inc     = VAL_W'(pos_reg) + VAL_W'(1);
    assign frame_end   = (pos_inc == frame_length_reg);
    assign pos_mod_inc = pos_mod_reg + POS_W'(1);
    assign epoch_wrap  = (epoch_reg == EPOCH_LAST);

    // Handshakes.
    assign in_stall      = (state_reg != ST_IDLE);
    assign in_xfer       = in_valid && !in_stall;
    assign out_free      = !out_valid_reg || !out_stall;
    assign cfg_restart   = cfg_we && (state_reg != ST_CLEAR);

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR:
            begin
                if (clr_cnt_reg == LAST_ADDR)
                begin
                    state_next = ST_CHECK_INIT;
                end
            end
            ST_CHECK_INIT:
            begin
                state_next = (period_ok && length_ok) ? ST_CHECK : ST_IDLE;
            end
            ST_CHECK:
            begin
                if (fold_done)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = (!cfg_ok_reg || draw_oor) ? ST_EMIT : ST_FOLD;
                end
            end
            ST_FOLD:
            begin
                if (fold_done)
                begin
                    state_next = cand_ok ? ST_DECIDE : ST_EMIT;
                end
            end
            ST_DECIDE:
            begin
                state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (out_free)
                begin
                    state_next = clear_pend_reg ? ST_CLEAR : ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_CLEAR;
            end
        endcase
        if (cfg_restart)
        begin
            state_next = epoch_wrap ? ST_CLEAR : ST_CHECK_INIT;
        end
    end

    // Memory port selection: the clearing pass or the write-back of a free entry.
    always_comb
    begin
        mem_we    = 1'b0;
        mem_waddr = AW'(cand_reg);
        mem_wdata = epoch_reg;
        if (state_reg == ST_CLEAR)
        begin
            mem_we    = 1'b1;
            mem_waddr = clr_cnt_reg;
            mem_wdata = EPOCH_FREE;
        end
        else if ((state_reg == ST_DECIDE) && !entry_used)
        begin
            mem_we = 1'b1;
        end
    end

    // The read is issued in the cycle that the fold finishes.
    assign mem_raddr = AW'(cand_calc);

    // Used map of epoch marks.
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        rd_data_reg <= mem[mem_raddr];
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_CLEAR;
            period_bits_reg  <= PBITS_RESET;
            frame_length_reg <= FLEN_RESET;
            cfg_ok_reg       <= 1'b0;
            pos_reg          <= '0;
            pos_mod_reg      <= '0;
            epoch_reg        <= EPOCH_FIRST;
            clear_pend_reg   <= 1'b0;
            clr_cnt_reg      <= '0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;

            // Clearing pass address.
            if ((state_reg != ST_CLEAR) || (clr_cnt_reg == LAST_ADDR))
            begin
                clr_cnt_reg <= '0;
            end
            else
            begin
                clr_cnt_reg <= clr_cnt_reg + AW'(1);
            end

            // Configuration check result.
            if (state_reg == ST_CHECK_INIT)
            begin
                cfg_ok_reg <= 1'b0;
            end
            else if ((state_reg == ST_CHECK) && fold_done)
            begin
                cfg_ok_reg <= (fold_rem == '0);
            end

            // Position advance on a free entry, frame restart on the last one.
            if ((state_reg == ST_DECIDE) && !entry_used)
            begin
                if (frame_end)
                begin
                    pos_reg        <= '0;
                    pos_mod_reg    <= '0;
                    epoch_reg      <= epoch_wrap ? EPOCH_FIRST : epoch_reg + EPOCH_W'(1);
                    clear_pend_reg <= epoch_wrap;
                end
                else
                begin
                    pos_reg     <= pos_inc[POS_W-1:0];
                    pos_mod_reg <= (PER_W'(pos_mod_inc) == period_val) ? '0 : pos_mod_inc;
                end
            end

            // Output register valid.
            if ((state_reg == ST_EMIT) && out_free)
            begin
                out_valid_reg  <= 1'b1;
                clear_pend_reg <= 1'b0;
            end
            else if (out_valid_reg && !out_stall)
            begin
                out_valid_reg <= 1'b0;
            end

            // Register writes restart the frame.
            if (cfg_we)
            begin
                unique case (cfg_index)
                    REG_PERIOD_BITS:  period_bits_reg  <= cfg_data[PBITS_W-1:0];
                    REG_FRAME_LENGTH: frame_length_reg <= cfg_data[FLEN_W-1:0];
                    default:          ;
                endcase
                pos_reg     <= '0;
                pos_mod_reg <= '0;
                cfg_ok_reg  <= 1'b0;
                if (cfg_restart)
                begin
                    epoch_reg <= epoch_wrap ? EPOCH_FIRST : epoch_reg + EPOCH_W'(1);
                end
            end
        end
    end

    // Item payload and result registers.
    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            draw_reg       <= random_draw;
            item_pos_reg   <= pos_reg;
            x_reg          <= VAL_W'(random_draw);
            res_err_reg    <= !cfg_ok_reg;
            res_accept_reg <= 1'b0;
            res_last_reg   <= 1'b0;
            res_mapped_reg <= '0;
        end
        else if (state_reg == ST_CHECK_INIT)
        begin
            x_reg <= frame_length_reg;
        end
        else if (((state_reg == ST_CHECK) || (state_reg == ST_FOLD)) && !fold_done)
        begin
            x_reg <= fold_sum;
        end

        if ((state_reg == ST_FOLD) && fold_done)
        begin
            cand_reg <= cand_calc;
            if (cand_ok)
            begin
                res_mapped_reg <= cand_calc[IDX_W-1:0];
            end
        end

        if (state_reg == ST_DECIDE)
        begin
            res_accept_reg <= !entry_used;
            res_last_reg   <= !entry_used && frame_end;
        end

        if ((state_reg == ST_EMIT) && out_free)
        begin
            out_accept_reg <= res_accept_reg;
            out_pos_reg    <= item_pos_reg;
            out_mapped_reg <= res_mapped_reg;
            out_last_reg   <= res_last_reg;
            out_err_reg    <= res_err_reg;
        end
    end

    assign out_valid    = out_valid_reg;
    assign accepted     = out_accept_reg;
    assign position     = out_pos_reg;
    assign mapped_index = out_mapped_reg;
    assign frame_last   = out_last_reg;
    assign config_error = out_err_reg;

endmodule

// ----- src/stig_checker.sv -----
module stig_checker
    import stig_pkg::*;
(
    input logic             clk,
    input logic             rst_n,
    input logic             in_valid,
    input logic             in_stall,
    input logic             out_valid,
    input logic             out_stall,
    input logic             accepted,
    input logic [POS_W-1:0] position,
    input logic [IDX_W-1:0] mapped_index,
    input logic             frame_last,
    input logic             config_error
);

    // A stalled result holds until its transfer.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(accepted) && $stable(position)
            && $stable(mapped_index) && $stable(frame_last) && $stable(config_error))
        else $error("stalled result changed");

    // Only an accepted entry can close a frame.
    a_last_accepted: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && frame_last |-> accepted)
        else $error("frame_last on a rejected draw");

    // A configuration error result carries no entry.
    a_err_shape: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && config_error |-> !accepted && !frame_last && (mapped_index == '0))
        else $error("config_error result carries an entry");

    // One draw at a time: the input stalls right after a transfer.
    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("input not stalled after a transfer");

endmodule

bind self_terminating_interleaver_gen_top stig_checker u_stig_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .accepted     (accepted),
    .position     (position),
    .mapped_index (mapped_index),
    .frame_last   (frame_last),
    .config_error (config_error)
);
